### src/seq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted event queue package
// Shared defaults, operation and status codes, controller/datapath bundles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package seq_pkg;

    // default configuration
    localparam int CAPACITY_DEF  = 64;
    localparam int TIME_BITS_DEF = 32;
    localparam int KIND_BITS_DEF = 8;
    localparam int DATA_BITS     = 32;
    localparam int CNT_BITS_DEF  = $clog2(CAPACITY_DEF + 1);

    // operation codes carried in the mode field
    typedef enum logic [1:0] {
        MODE_SCHEDULE = 2'd0,
        MODE_POP      = 2'd1,
        MODE_PEEK     = 2'd2,
        MODE_CLEAR    = 2'd3
    } t_mode;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // commands from controller to datapath
    typedef struct packed {
        logic    capture;   // latch the incoming beat
        logic    load_out;  // load the result register
        logic    insert;    // sorted insert of the latched event
        logic    pop;       // shift the slots down by one towards slot zero
        logic    clear;     // drop all entries
        logic    show_head; // report slot zero in the result
        t_status status;    // status code of the result
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        t_mode mode;
        logic  empty;
        logic  full;
    } t_stat;

endpackage

### src/seq_ifs.sv
// ----------------------------------------------------------------------------
// Sorted event queue channels
// Valid/ready channels for operation beats in and result beats out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface seq_in_if #(
    parameter int TIME_BITS = seq_pkg::TIME_BITS_DEF,
    parameter int KIND_BITS = seq_pkg::KIND_BITS_DEF
);
    logic                              valid;
    logic                              ready;
    logic [1:0]                        mode;
    logic [TIME_BITS-1:0]              event_time;
    logic [KIND_BITS-1:0]              event_kind;
    logic signed [seq_pkg::DATA_BITS-1:0] event_data;

    modport source (output valid, output mode, output event_time, output event_kind,
                    output event_data, input ready);
    modport sink   (input valid, input mode, input event_time, input event_kind,
                    input event_data, output ready);
endinterface

interface seq_out_if #(
    parameter int TIME_BITS = seq_pkg::TIME_BITS_DEF,
    parameter int KIND_BITS = seq_pkg::KIND_BITS_DEF,
    parameter int CNT_BITS  = seq_pkg::CNT_BITS_DEF
);
    logic                              valid;
    logic                              ready;
    logic [1:0]                        status;
    logic [TIME_BITS-1:0]              head_time;
    logic [KIND_BITS-1:0]              head_kind;
    logic signed [seq_pkg::DATA_BITS-1:0] head_data;
    logic [CNT_BITS-1:0]               occupancy;

    modport source (output valid, output status, output head_time, output head_kind,
                    output head_data, output occupancy, input ready);
    modport sink   (input valid, input status, input head_time, input head_kind,
                    input head_data, input occupancy, output ready);
endinterface

### src/seq_ctrl.sv
// ----------------------------------------------------------------------------
// Sorted event queue controller
// Sequences capture and execution of one operation and owns both handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module seq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  seq_pkg::t_stat i_stat,
    output seq_pkg::t_cmd  o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_can_emit;

    // result register is free, or its beat leaves this cycle
    assign w_can_emit = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // decode the operation into datapath commands
    always_comb begin
        o_cmd         = '0;
        o_cmd.status  = seq_pkg::ST_OK;
        o_cmd.capture = (r_state == S_IDLE) && i_in_valid;
        if (r_state == S_EXEC && w_can_emit) begin
            o_cmd.load_out = 1'b1;
            case (i_stat.mode)
                seq_pkg::MODE_SCHEDULE: begin
                    if (i_stat.full) begin
                        o_cmd.status = seq_pkg::ST_FULL;
                    end else begin
                        o_cmd.insert = 1'b1;
                    end
                end
                seq_pkg::MODE_POP: begin
                    if (i_stat.empty) begin
                        o_cmd.status = seq_pkg::ST_EMPTY;
                    end else begin
                        o_cmd.pop       = 1'b1;
                        o_cmd.show_head = 1'b1;
                    end
                end
                seq_pkg::MODE_PEEK: begin
                    if (i_stat.empty) begin
                        o_cmd.status = seq_pkg::ST_EMPTY;
                    end else begin
                        o_cmd.show_head = 1'b1;
                    end
                end
                seq_pkg::MODE_CLEAR: begin
                    o_cmd.clear = 1'b1;
                end
                default: begin
                    o_cmd.status = seq_pkg::ST_OK;
                end
            endcase
        end
    end

    // next state and result valid
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_can_emit) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // hold state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### src/seq_datapath.sv
// ----------------------------------------------------------------------------
// Sorted event queue datapath
// Row of sorted slots with parallel time compare, insert shift and pop shift.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module seq_datapath #(
    parameter int CAPACITY  = seq_pkg::CAPACITY_DEF,
    parameter int TIME_BITS = seq_pkg::TIME_BITS_DEF,
    parameter int KIND_BITS = seq_pkg::KIND_BITS_DEF,
    parameter int CNT_BITS  = $clog2(CAPACITY + 1)
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  seq_pkg::t_cmd                        i_cmd,
    output seq_pkg::t_stat                       o_stat,
    input  logic [1:0]                           i_mode,
    input  logic [TIME_BITS-1:0]                 i_event_time,
    input  logic [KIND_BITS-1:0]                 i_event_kind,
    input  logic signed [seq_pkg::DATA_BITS-1:0] i_event_data,
    output logic [1:0]                           o_status,
    output logic [TIME_BITS-1:0]                 o_head_time,
    output logic [KIND_BITS-1:0]                 o_head_kind,
    output logic signed [seq_pkg::DATA_BITS-1:0] o_head_data,
    output logic [CNT_BITS-1:0]                  o_occupancy
);

    // latched operation
    logic [1:0]                           r_mode;
    logic [TIME_BITS-1:0]                 r_time;
    logic [KIND_BITS-1:0]                 r_kind;
    logic signed [seq_pkg::DATA_BITS-1:0] r_data;

    // slot row, slot zero holds the earliest entry
    logic [TIME_BITS-1:0]                 r_slot_time [CAPACITY];
    logic [KIND_BITS-1:0]                 r_slot_kind [CAPACITY];
    logic signed [seq_pkg::DATA_BITS-1:0] r_slot_data [CAPACITY];

    logic [CNT_BITS-1:0]                  r_count, n_count;

    // result register
    logic [1:0]                           r_status;
    logic [TIME_BITS-1:0]                 r_head_time;
    logic [KIND_BITS-1:0]                 r_head_kind;
    logic signed [seq_pkg::DATA_BITS-1:0] r_head_data;
    logic [CNT_BITS-1:0]                  r_occ;

    // slot holds a later time than the new event, or lies past the last entry
    logic [CAPACITY-1:0]                  w_gt;
    logic [CAPACITY-1:0]                  w_prev_gt;

    assign o_stat.mode  = seq_pkg::t_mode'(r_mode);
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CNT_BITS'(CAPACITY));

    assign w_prev_gt = {w_gt[CAPACITY-2:0], 1'b0};

    // latch the operation beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= i_mode;
            r_time <= i_event_time;
            r_kind <= i_event_kind;
            r_data <= i_event_data;
        end
    end

    // per-slot compare and update
    for (genvar g = 0; g < CAPACITY; g++) begin : g_slot
        assign w_gt[g] = (CNT_BITS'(g) >= r_count) || (r_slot_time[g] > r_time);

        always_ff @(posedge i_clk) begin
            if (i_cmd.insert && w_gt[g]) begin
                if (w_prev_gt[g]) begin
                    // move up to make room below
                    if (g > 0) begin
                        r_slot_time[g] <= r_slot_time[(g > 0) ? g - 1 : 0];
                        r_slot_kind[g] <= r_slot_kind[(g > 0) ? g - 1 : 0];
                        r_slot_data[g] <= r_slot_data[(g > 0) ? g - 1 : 0];
                    end
                end else begin
                    // first later slot takes the new event
                    r_slot_time[g] <= r_time;
                    r_slot_kind[g] <= r_kind;
                    r_slot_data[g] <= r_data;
                end
            end else if (i_cmd.pop && g < CAPACITY - 1) begin
                // advance the row towards the head
                r_slot_time[g] <= r_slot_time[(g < CAPACITY - 1) ? g + 1 : g];
                r_slot_kind[g] <= r_slot_kind[(g < CAPACITY - 1) ? g + 1 : g];
                r_slot_data[g] <= r_slot_data[(g < CAPACITY - 1) ? g + 1 : g];
            end
        end
    end

    // entry count after the operation
    always_comb begin
        n_count = r_count;
        if (i_cmd.clear) begin
            n_count = '0;
        end else if (i_cmd.insert) begin
            n_count = r_count + CNT_BITS'(1);
        end else if (i_cmd.pop) begin
            n_count = r_count - CNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.load_out) begin
            r_count <= n_count;
        end
    end

    // load the result beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_status    <= i_cmd.status;
            r_occ       <= n_count;
            r_head_time <= i_cmd.show_head ? r_slot_time[0] : '0;
            r_head_kind <= i_cmd.show_head ? r_slot_kind[0] : '0;
            r_head_data <= i_cmd.show_head ? r_slot_data[0] : '0;
        end
    end

    assign o_status    = r_status;
    assign o_head_time = r_head_time;
    assign o_head_kind = r_head_kind;
    assign o_head_data = r_head_data;
    assign o_occupancy = r_occ;

endmodule

### src/sorted_event_queue_core.sv
// ----------------------------------------------------------------------------
// Sorted event queue core
// An accepted operation beat is latched, then executed into the result register
// once that register is free; the controller takes a new beat only after the
// previous one has executed. The slot row compares and shifts in parallel.
// Reset clears the entry count and handshake state; slot contents are left
// as they are and need no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_event_queue_core #(
    parameter int CAPACITY  = seq_pkg::CAPACITY_DEF,
    parameter int TIME_BITS = seq_pkg::TIME_BITS_DEF,
    parameter int KIND_BITS = seq_pkg::KIND_BITS_DEF,
    parameter int CNT_BITS  = $clog2(CAPACITY + 1)
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    seq_in_if.sink    i_in,
    seq_out_if.source o_out
);

    seq_pkg::t_cmd  w_cmd;
    seq_pkg::t_stat w_stat;

    // handshake and operation sequencing
    seq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // slot row and result register
    seq_datapath #(
        .CAPACITY  (CAPACITY),
        .TIME_BITS (TIME_BITS),
        .KIND_BITS (KIND_BITS),
        .CNT_BITS  (CNT_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_mode       (i_in.mode),
        .i_event_time (i_in.event_time),
        .i_event_kind (i_in.event_kind),
        .i_event_data (i_in.event_data),
        .o_status     (o_out.status),
        .o_head_time  (o_out.head_time),
        .o_head_kind  (o_out.head_kind),
        .o_head_data  (o_out.head_data),
        .o_occupancy  (o_out.occupancy)
    );

endmodule

### sim/sorted_event_queue_core_test.sv
// ----------------------------------------------------------------------------
// Sorted event queue core testbench
// Drives schedule, pop, peek and clear beats into the core and checks every
// result beat against a behavioural queue kept in the bench. A short table
// covers the empty, extreme and equal-time cases. Random bursts then fill the
// queue to capacity, drain it and mix all operations, under changing idle and
// stall patterns on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_event_queue_core_test;

    localparam int ITEM_TOTAL     = 1600;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 10;

    // one result beat as the core should present it
    typedef struct packed {
        seq_pkg::t_status   status;
        logic [31:0]        head_time;
        logic [7:0]         head_kind;
        logic signed [31:0] head_data;
        logic [6:0]         occupancy;
    } t_outcome;

    // one stored event of the behavioural queue
    typedef struct packed {
        logic [31:0]        ev_time;
        logic [7:0]         ev_kind;
        logic signed [31:0] ev_data;
    } t_event;

    // one row of the directed table; typed rows carry their own expectation
    typedef struct packed {
        seq_pkg::t_mode     op;
        logic [31:0]        ev_time;
        logic [7:0]         ev_kind;
        logic signed [31:0] ev_data;
        logic               typed;
        t_outcome           res;
    } t_stim_row;

    typedef enum int {
        BURST_FILL,
        BURST_DRAIN,
        BURST_MIXED
    } t_burst;

    localparam t_outcome NO_RES    = '{seq_pkg::ST_OK, 32'd0, 8'd0, 32'sd0, 7'd0};
    localparam int       ROW_COUNT = 22;

    localparam t_stim_row DIRECTED [ROW_COUNT] = '{
        '{seq_pkg::MODE_POP,      32'h0,        8'h00, 32'sh0,        1'b1,
          '{seq_pkg::ST_EMPTY, 32'h0, 8'h00, 32'sh0, 7'd0}},
        '{seq_pkg::MODE_PEEK,     32'h0,        8'h00, 32'sh0,        1'b1,
          '{seq_pkg::ST_EMPTY, 32'h0, 8'h00, 32'sh0, 7'd0}},
        '{seq_pkg::MODE_CLEAR,    32'h0,        8'h00, 32'sh0,        1'b1,
          '{seq_pkg::ST_OK, 32'h0, 8'h00, 32'sh0, 7'd0}},
        '{seq_pkg::MODE_SCHEDULE, 32'hFFFFFFFF, 8'hFF, 32'sh7FFFFFFF, 1'b1,
          '{seq_pkg::ST_OK, 32'h0, 8'h00, 32'sh0, 7'd1}},
        '{seq_pkg::MODE_SCHEDULE, 32'h0,        8'h00, 32'sh80000000, 1'b1,
          '{seq_pkg::ST_OK, 32'h0, 8'h00, 32'sh0, 7'd2}},
        '{seq_pkg::MODE_SCHEDULE, 32'd100,      8'h01, 32'shFFFFFFFF, 1'b1,
          '{seq_pkg::ST_OK, 32'h0, 8'h00, 32'sh0, 7'd3}},
        '{seq_pkg::MODE_SCHEDULE, 32'd100,      8'h02, 32'sh5,        1'b1,
          '{seq_pkg::ST_OK, 32'h0, 8'h00, 32'sh0, 7'd4}},
        '{seq_pkg::MODE_SCHEDULE, 32'd100,      8'h03, 32'shA5A5A5A5, 1'b1,
          '{seq_pkg::ST_OK, 32'h0, 8'h00, 32'sh0, 7'd5}},
        '{seq_pkg::MODE_PEEK,     32'h0,        8'h00, 32'sh0,        1'b1,
          '{seq_pkg::ST_OK, 32'h0, 8'h00, 32'sh80000000, 7'd5}},
        '{seq_pkg::MODE_POP,      32'hFFFFFFFF, 8'hFF, 32'shFFFFFFFF, 1'b1,
          '{seq_pkg::ST_OK, 32'h0, 8'h00, 32'sh80000000, 7'd4}},
        '{seq_pkg::MODE_POP,      32'h0,        8'h00, 32'sh0,        1'b0, NO_RES},
        '{seq_pkg::MODE_POP,      32'h12345678, 8'h5A, 32'sh0,        1'b0, NO_RES},
        '{seq_pkg::MODE_PEEK,     32'hFFFFFFFF, 8'hFF, 32'sh7FFFFFFF, 1'b0, NO_RES},
        '{seq_pkg::MODE_POP,      32'h0,        8'h00, 32'sh0,        1'b0, NO_RES},
        '{seq_pkg::MODE_POP,      32'h0,        8'h00, 32'sh0,        1'b1,
          '{seq_pkg::ST_OK, 32'hFFFFFFFF, 8'hFF, 32'sh7FFFFFFF, 7'd0}},
        '{seq_pkg::MODE_POP,      32'h0,        8'h00, 32'sh0,        1'b1,
          '{seq_pkg::ST_EMPTY, 32'h0, 8'h00, 32'sh0, 7'd0}},
        '{seq_pkg::MODE_SCHEDULE, 32'd7,        8'h10, 32'sh1234,     1'b1,
          '{seq_pkg::ST_OK, 32'h0, 8'h00, 32'sh0, 7'd1}},
        '{seq_pkg::MODE_SCHEDULE, 32'd7,        8'h11, 32'sh5678,     1'b1,
          '{seq_pkg::ST_OK, 32'h0, 8'h00, 32'sh0, 7'd2}},
        '{seq_pkg::MODE_CLEAR,    32'hFFFFFFFF, 8'hFF, 32'shFFFFFFFF, 1'b1,
          '{seq_pkg::ST_OK, 32'h0, 8'h00, 32'sh0, 7'd0}},
        '{seq_pkg::MODE_PEEK,     32'h0,        8'h00, 32'sh0,        1'b1,
          '{seq_pkg::ST_EMPTY, 32'h0, 8'h00, 32'sh0, 7'd0}},
        '{seq_pkg::MODE_SCHEDULE, 32'h0,        8'h00, 32'sh0,        1'b1,
          '{seq_pkg::ST_OK, 32'h0, 8'h00, 32'sh0, 7'd1}},
        '{seq_pkg::MODE_CLEAR,    32'h0,        8'h00, 32'sh0,        1'b1,
          '{seq_pkg::ST_OK, 32'h0, 8'h00, 32'sh0, 7'd0}}
    };

    logic i_clk;
    logic i_rst_n;

    seq_in_if  in_ch ();
    seq_out_if out_ch ();

    sorted_event_queue_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_event   shadow_events [$];
    t_outcome due_results [$];
    int       mismatch_count;
    int       items_sent;
    int       send_idle_pct;
    int       recv_stall_pct;
    int       quiet_cycles;

    // clock
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // apply one operation to the behavioural queue and return its result
    function automatic t_outcome predict_result(seq_pkg::t_mode op, logic [31:0] t,
                                                logic [7:0] k, logic signed [31:0] d);
        t_outcome res;
        int       pos;
        t_event   ev;
        res = NO_RES;
        pos = 0;
        ev  = '{t, k, d};
        case (op)
            seq_pkg::MODE_SCHEDULE: begin
                if (shadow_events.size() >= seq_pkg::CAPACITY_DEF) begin
                    res.status = seq_pkg::ST_FULL;
                end else begin
                    // land after every entry not later than the new one
                    while (pos < shadow_events.size() && shadow_events[pos].ev_time <= t)
                        pos++;
                    shadow_events.insert(pos, ev);
                end
            end
            seq_pkg::MODE_CLEAR: begin
                shadow_events.delete();
            end
            default: begin
                if (shadow_events.size() == 0) begin
                    res.status = seq_pkg::ST_EMPTY;
                end else begin
                    res.head_time = shadow_events[0].ev_time;
                    res.head_kind = shadow_events[0].ev_kind;
                    res.head_data = shadow_events[0].ev_data;
                    if (op == seq_pkg::MODE_POP)
                        void'(shadow_events.pop_front());
                end
            end
        endcase
        res.occupancy = 7'(shadow_events.size());
        return res;
    endfunction

    // hold the sender until every outstanding result has come back
    task automatic pause_until_drained();
        in_ch.valid <= 1'b0;
        wait (due_results.size() == 0);
        @(posedge i_clk);
    endtask

    // drive one operation beat and record its expected result on acceptance
    task automatic issue_op(seq_pkg::t_mode op, logic [31:0] t, logic [7:0] k,
                            logic signed [31:0] d, logic typed, t_outcome typed_res);
        t_outcome res;
        // switch idle pattern at the thirds of the run, after a full drain
        if (items_sent == ITEM_TOTAL / 3) begin
            pause_until_drained();
            send_idle_pct  = 48;
            recv_stall_pct = 20;
        end else if (items_sent == 2 * ITEM_TOTAL / 3) begin
            pause_until_drained();
            send_idle_pct  = 0;
            recv_stall_pct = 0;
        end
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.mode       <= op;
        in_ch.event_time <= t;
        in_ch.event_kind <= k;
        in_ch.event_data <= d;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        res = predict_result(op, t, k, d);
        due_results.push_back(typed ? typed_res : res);
        items_sent++;
    endtask

    // pick an event time: often a narrow band for ties, some extremes, else random
    function automatic logic [31:0] pick_time();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return 32'($urandom_range(0, 31));
        else if (roll < 55)
            return 32'hFFFFFFFF - 32'($urandom_range(0, 3));
        else if (roll < 60)
            return 32'h0;
        else
            return 32'($urandom);
    endfunction

    // one stretch of random operations with a given bias
    task automatic random_burst(t_burst flavour, int len);
        int             sched_pct;
        int             pop_pct;
        int             peek_pct;
        int             roll;
        seq_pkg::t_mode op;
        case (flavour)
            BURST_FILL:  begin sched_pct = 90; pop_pct = 5;  peek_pct = 5;  end
            BURST_DRAIN: begin sched_pct = 15; pop_pct = 70; peek_pct = 15; end
            default:     begin sched_pct = 45; pop_pct = 30; peek_pct = 20; end
        endcase
        for (int i = 0; i < len && items_sent < ITEM_TOTAL; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < sched_pct)
                op = seq_pkg::MODE_SCHEDULE;
            else if (roll < sched_pct + pop_pct)
                op = seq_pkg::MODE_POP;
            else if (roll < sched_pct + pop_pct + peek_pct)
                op = seq_pkg::MODE_PEEK;
            else
                op = seq_pkg::MODE_CLEAR;
            issue_op(op, pick_time(), 8'($urandom_range(0, 255)), 32'($urandom),
                     1'b0, NO_RES);
        end
    endtask

    // result side: check each accepted beat, then decide next cycle's ready
    always @(posedge i_clk) begin
        t_outcome want;
        t_outcome got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = '{seq_pkg::t_status'(out_ch.status), out_ch.head_time, out_ch.head_kind,
                    out_ch.head_data, out_ch.occupancy};
            if (due_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT) begin
                    $display("%0t: unexpected result beat", $realtime);
                    $display("  actual   status=%0d time=%h kind=%h data=%h occ=%0d",
                             got.status, got.head_time, got.head_kind,
                             got.head_data, got.occupancy);
                end
            end else begin
                want = due_results.pop_front();
                if (got.status !== want.status || got.head_time !== want.head_time ||
                    got.head_kind !== want.head_kind || got.head_data !== want.head_data ||
                    got.occupancy !== want.occupancy) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("%0t: result mismatch", $realtime);
                        $display("  expected status=%0d time=%h kind=%h data=%h occ=%0d",
                                 want.status, want.head_time, want.head_kind,
                                 want.head_data, want.occupancy);
                        $display("  actual   status=%0d time=%h kind=%h data=%h occ=%0d",
                                 got.status, got.head_time, got.head_kind,
                                 got.head_data, got.occupancy);
                    end
                end
            end
        end
        out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // watchdog: end the run when no beat moves for too long
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // stimulus
    initial begin
        t_burst flavour;
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.mode       = seq_pkg::MODE_SCHEDULE;
        in_ch.event_time = '0;
        in_ch.event_kind = '0;
        in_ch.event_data = '0;
        out_ch.ready     = 1'b0;
        mismatch_count   = 0;
        items_sent       = 0;
        quiet_cycles     = 0;
        send_idle_pct    = 20;
        recv_stall_pct   = 48;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // walk the directed table
        for (int r = 0; r < ROW_COUNT; r++)
            issue_op(DIRECTED[r].op, DIRECTED[r].ev_time, DIRECTED[r].ev_kind,
                     DIRECTED[r].ev_data, DIRECTED[r].typed, DIRECTED[r].res);
        pause_until_drained();

        // random bursts, starting with a fill so that the full case comes early
        flavour = BURST_FILL;
        while (items_sent < ITEM_TOTAL) begin
            random_burst(flavour, (flavour == BURST_FILL) ? $urandom_range(70, 110)
                                                          : $urandom_range(30, 90));
            flavour = t_burst'($urandom_range(0, 2));
        end

        // let the last results arrive
        in_ch.valid <= 1'b0;
        wait (due_results.size() == 0);
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && due_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
src/seq_pkg.sv
src/seq_ifs.sv
src/seq_ctrl.sv
src/seq_datapath.sv
src/sorted_event_queue_core.sv
sim/sorted_event_queue_core_test.sv
